// ===== design/ega_rpd_pkg.sv =====
package ega_rpd_pkg;

    typedef logic [7:0] byte_t;

    // plane order within one row
    typedef enum logic [1:0] {
        PLANE_BLUE      = 2'd0,
        PLANE_GREEN     = 2'd1,
        PLANE_RED       = 2'd2,
        PLANE_INTENSITY = 2'd3
    } plane_t;

    localparam int PIXELS_PER_BYTE = 8;
    localparam int COLOR_PLANES    = 3;

    // config register map
    localparam logic CFG_BYTES_PER_PLANE = 1'b0;
    localparam logic [5:0] BPP_RESET     = 6'd2;

    // palette levels
    localparam byte_t LVL_OFF  = 8'h00;
    localparam byte_t LVL_LOW  = 8'h54;
    localparam byte_t LVL_MID  = 8'hA8;
    localparam byte_t LVL_HIGH = 8'hFE;

    typedef struct packed {
        byte_t red;
        byte_t green;
        byte_t blue;
    } rgb_t;

    function automatic rgb_t palette_rgb(input logic [3:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0:  c = '{LVL_OFF,  LVL_OFF,  LVL_OFF};
            4'd1:  c = '{LVL_OFF,  LVL_OFF,  LVL_MID};
            4'd2:  c = '{LVL_OFF,  LVL_MID,  LVL_OFF};
            4'd3:  c = '{LVL_OFF,  LVL_MID,  LVL_MID};
            4'd4:  c = '{LVL_MID,  LVL_OFF,  LVL_OFF};
            4'd5:  c = '{LVL_MID,  LVL_OFF,  LVL_MID};
            4'd6:  c = '{LVL_MID,  LVL_LOW,  LVL_OFF};
            4'd7:  c = '{LVL_MID,  LVL_MID,  LVL_MID};
            4'd8:  c = '{LVL_LOW,  LVL_LOW,  LVL_LOW};
            4'd9:  c = '{LVL_LOW,  LVL_LOW,  LVL_HIGH};
            4'd10: c = '{LVL_LOW,  LVL_HIGH, LVL_LOW};
            4'd11: c = '{LVL_LOW,  LVL_HIGH, LVL_HIGH};
            4'd12: c = '{LVL_HIGH, LVL_LOW,  LVL_LOW};
            4'd13: c = '{LVL_HIGH, LVL_LOW,  LVL_HIGH};
            4'd14: c = '{LVL_HIGH, LVL_HIGH, LVL_LOW};
            4'd15: c = '{LVL_HIGH, LVL_HIGH, LVL_HIGH};
            default: c = '{LVL_OFF, LVL_OFF, LVL_OFF};
        endcase
        return c;
    endfunction

endpackage

// ===== design/ega_rpd_if.sv =====
interface ega_rpd_in_if;
    logic                  valid;
    logic                  ready;
    ega_rpd_pkg::byte_t    data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ega_rpd_out_if;
    logic                  valid;
    logic                  ready;
    logic [3:0]            palette_index;
    ega_rpd_pkg::byte_t    red;
    ega_rpd_pkg::byte_t    green;
    ega_rpd_pkg::byte_t    blue;
    logic [7:0]            column;
    logic                  row_end;
    logic                  last;

    modport source (output valid, output palette_index, output red, output green,
                    output blue, output column, output row_end, output last,
                    input ready);
    modport sink   (input valid, input palette_index, input red, input green,
                    input blue, input column, input row_end, input last,
                    output ready);
endinterface

// ===== design/ega_rpd_ram.sv =====
module ega_rpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    parameter int LANES = 3
) (
    input  logic                                       clk,
    input  logic [LANES-1:0]                           we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    localparam int LW = WIDTH / LANES;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (we[l])
            begin
                mem[waddr][l*LW +: LW] <= wdata[l*LW +: LW];
            end
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ega_row_planar_pixel_decoder.sv =====
// row-planar ega sprite decoder with a 16-color palette
//
// in_ch takes one plane byte per item; each row is bytes_per_plane bytes of
// blue, then green, then red, then intensity. blue, green and red bytes are
// written into a row store (one ram, one byte lane per color plane) and give
// no result. each intensity byte reads the matching store entry and gives
// eight pixel items on out_ch, leftmost pixel (msb) first.
//
// an intensity byte is held in the read stage during the ram read, then loaded
// into the serializer, which writes its pixels to the output register. color
// bytes go in one per cycle; the serializer puts out one pixel per cycle while
// the output register is free, eight per intensity byte. one intensity byte may
// wait in the read stage while the previous one shifts out, and color bytes
// of the next row keep flowing meanwhile.
//
// bytes_per_plane is written through the apb port at address 0; the user must
// write it only while idle, the block does not enforce it. 0 acts as 1 and
// values above MAX_BYTES_PER_PLANE are clamped. reset clears the plane and byte
// position, sets bytes_per_plane to 2 and empties the pipeline; the store
// content is not cleared. a stalled receiver holds the output register; the
// serializer, then the read stage fill up; then intensity bytes wait on in_ch.
module ega_row_planar_pixel_decoder #(
    parameter int MAX_BYTES_PER_PLANE = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // apb config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // item channels
    ega_rpd_in_if.sink           in_ch,
    ega_rpd_out_if.source        out_ch
);

    // position width, compare width, column source width
    localparam int PW  = (MAX_BYTES_PER_PLANE > 1) ? $clog2(MAX_BYTES_PER_PLANE) : 1;
    localparam int CW  = ((PW + 1) > 6) ? (PW + 1) : 6;
    localparam int CLW = ((PW + 3) > 8) ? (PW + 3) : 8;
    localparam int SW  = ega_rpd_pkg::COLOR_PLANES * 8;

    // config register
    logic [5:0]  bpp_reg;
    logic [5:0]  bpp_next;

    // row tracking
    logic [PW-1:0]          pos_reg;
    logic [PW-1:0]          pos_next;
    ega_rpd_pkg::plane_t    plane_reg;
    ega_rpd_pkg::plane_t    plane_next;

    logic [CW-1:0]  width_eff;
    logic [CW-1:0]  bpp_ext;
    logic [CW-1:0]  max_ext;
    logic [CW-1:0]  pos_inc;
    logic           row_done;
    logic           in_fire;
    logic           in_ready;
    logic           is_intensity;

    // store access
    logic [ega_rpd_pkg::COLOR_PLANES-1:0] store_we;
    logic                                 store_re;
    logic [SW-1:0]                        store_rdata;

    // read stage: intensity byte waiting for store data
    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [7:0]     s1_int_reg;
    logic [PW-1:0]  s1_pos_reg;
    logic           s1_final_reg;
    logic           s1_load;

    // pixel serializer
    logic           ser_valid_reg;
    logic           ser_valid_next;
    logic [2:0]     ser_cnt_reg;
    logic [2:0]     ser_cnt_next;
    logic [7:0]     ser_b_reg;
    logic [7:0]     ser_g_reg;
    logic [7:0]     ser_r_reg;
    logic [7:0]     ser_i_reg;
    logic [PW-1:0]  ser_pos_reg;
    logic           ser_final_reg;
    logic           ser_step;
    logic           ser_free;
    logic           ser_is_last;

    // current pixel
    logic [3:0]               pix_index;
    ega_rpd_pkg::rgb_t        pix_rgb;
    logic [CLW-1:0]           pix_col_full;

    // output register
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_free;
    logic [3:0]     out_index_reg;
    logic [7:0]     out_red_reg;
    logic [7:0]     out_green_reg;
    logic [7:0]     out_blue_reg;
    logic [7:0]     out_column_reg;
    logic           out_row_end_reg;
    logic           out_last_reg;

    // ------------------------------------------------------------------
    // apb register
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        bpp_next = bpp_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == ega_rpd_pkg::CFG_BYTES_PER_PLANE))
        begin
            bpp_next = pwdata[5:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == ega_rpd_pkg::CFG_BYTES_PER_PLANE)
        begin
            prdata = {26'd0, bpp_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    // ------------------------------------------------------------------
    // row position and plane
    // ------------------------------------------------------------------
    assign bpp_ext = CW'(bpp_reg);
    assign max_ext = CW'(MAX_BYTES_PER_PLANE);

    // zero acts as one, oversize clamps to the store depth
    always_comb
    begin
        priority if (bpp_reg == 6'd0)
        begin
            width_eff = CW'(1);
        end
        else if (bpp_ext > max_ext)
        begin
            width_eff = max_ext;
        end
        else
        begin
            width_eff = bpp_ext;
        end
    end

    assign pos_inc      = CW'(pos_reg) + CW'(1);
    assign row_done     = (pos_inc >= width_eff);
    assign is_intensity = (plane_reg == ega_rpd_pkg::PLANE_INTENSITY);

    // handshake in: color bytes always fit, an intensity byte needs the read stage
    assign in_ready     = !is_intensity || !s1_valid_reg || s1_load;
    assign in_ch.ready  = in_ready;
    assign in_fire      = in_ch.valid && in_ready;

    always_comb
    begin
        pos_next   = pos_reg;
        plane_next = plane_reg;
        if (in_fire)
        begin
            if (row_done)
            begin
                pos_next   = '0;
                plane_next = ega_rpd_pkg::plane_t'(plane_reg + 2'd1);
            end
            else
            begin
                pos_next = pos_inc[PW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // row store: color bytes write their lane, intensity reads all three.
    // one access per accepted item, so a write and a read of one entry
    // never meet in the same cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        store_we = '0;
        if (in_fire && !is_intensity)
        begin
            store_we[plane_reg] = 1'b1;
        end
    end

    assign store_re = in_fire && is_intensity;

    ega_rpd_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_BYTES_PER_PLANE),
        .LANES (ega_rpd_pkg::COLOR_PLANES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (pos_reg),
        .wdata ({ega_rpd_pkg::COLOR_PLANES{in_ch.data_byte}}),
        .re    (store_re),
        .raddr (pos_reg),
        .rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // read stage; ram data holds while no new read is issued
    // ------------------------------------------------------------------
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign ser_step    = ser_valid_reg && out_free;
    assign ser_is_last = (ser_cnt_reg == 3'd7);
    assign ser_free    = !ser_valid_reg || (ser_step && ser_is_last);
    assign s1_load     = s1_valid_reg && ser_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (store_re)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // serializer: msb first; while the output register is free, one pixel per cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;
        if (s1_load)
        begin
            ser_valid_next = 1'b1;
            ser_cnt_next   = 3'd0;
        end
        else if (ser_step)
        begin
            ser_cnt_next = ser_cnt_reg + 3'd1;
            if (ser_is_last)
            begin
                ser_valid_next = 1'b0;
            end
        end
    end

    assign pix_index    = {ser_i_reg[7], ser_r_reg[7], ser_g_reg[7], ser_b_reg[7]};
    assign pix_rgb      = ega_rpd_pkg::palette_rgb(pix_index);
    // column wraps at 256
    assign pix_col_full = CLW'({ser_pos_reg, ser_cnt_reg});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ser_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= ega_rpd_pkg::BPP_RESET;
            pos_reg       <= '0;
            plane_reg     <= ega_rpd_pkg::PLANE_BLUE;
            s1_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bpp_reg       <= bpp_next;
            pos_reg       <= pos_next;
            plane_reg     <= plane_next;
            s1_valid_reg  <= s1_valid_next;
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (store_re)
        begin
            s1_int_reg   <= in_ch.data_byte;
            s1_pos_reg   <= pos_reg;
            s1_final_reg <= row_done;
        end

        if (s1_load)
        begin
            ser_b_reg     <= store_rdata[7:0];
            ser_g_reg     <= store_rdata[15:8];
            ser_r_reg     <= store_rdata[23:16];
            ser_i_reg     <= s1_int_reg;
            ser_pos_reg   <= s1_pos_reg;
            ser_final_reg <= s1_final_reg;
        end
        else if (ser_step)
        begin
            ser_b_reg <= {ser_b_reg[6:0], 1'b0};
            ser_g_reg <= {ser_g_reg[6:0], 1'b0};
            ser_r_reg <= {ser_r_reg[6:0], 1'b0};
            ser_i_reg <= {ser_i_reg[6:0], 1'b0};
        end

        if (ser_step)
        begin
            out_index_reg   <= pix_index;
            out_red_reg     <= pix_rgb.red;
            out_green_reg   <= pix_rgb.green;
            out_blue_reg    <= pix_rgb.blue;
            out_column_reg  <= pix_col_full[7:0];
            out_row_end_reg <= ser_final_reg && ser_is_last;
            out_last_reg    <= ser_is_last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.palette_index = out_index_reg;
    assign out_ch.red           = out_red_reg;
    assign out_ch.green         = out_green_reg;
    assign out_ch.blue          = out_blue_reg;
    assign out_ch.column        = out_column_reg;
    assign out_ch.row_end       = out_row_end_reg;
    assign out_ch.last          = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // only intensity bytes are ever held off
    a_ready_only_intensity: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> is_intensity)
        else $error("input held off on a color plane");

    // an accepted intensity byte lands in the read stage
    a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        store_re |=> s1_valid_reg)
        else $error("intensity byte lost after store read");

    // the serializer only empties after its eighth pixel
    a_ser_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ser_valid_reg) |-> ($past(ser_cnt_reg) == 3'd7))
        else $error("serializer dropped a byte early");

    // the last mark sits on the eighth pixel of a byte
    a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_column_reg[2:0] == 3'd7))
        else $error("last mark off the byte boundary");

    // row end only on a byte's last pixel
    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_row_end_reg) |-> out_last_reg)
        else $error("row end without last mark");

endmodule

// ===== dv/ega_row_planar_pixel_decoder_tb.sv =====
module ega_row_planar_pixel_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BPP       = 32;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    // give color bytes time to land in the store and the pipeline time to empty
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // apb byte addresses: register index times four
    localparam logic [2:0] ADDR_BPP   = {ega_rpd_pkg::CFG_BYTES_PER_PLANE, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    // brown is the one palette entry that breaks the regular level pattern
    localparam logic [3:0] IDX_BROWN = 4'd6;

    typedef struct packed {
        logic [3:0]         idx;
        ega_rpd_pkg::byte_t red;
        ega_rpd_pkg::byte_t green;
        ega_rpd_pkg::byte_t blue;
        logic [7:0]         column;
        logic               row_end;
        logic               last;
    } pixel_t;

    // ------------------------------------------------------------------
    // pixel predictor and expected-pixel store
    // ------------------------------------------------------------------
    class pixel_scoreboard;
        ega_rpd_pkg::byte_t  plane_bytes[ega_rpd_pkg::COLOR_PLANES][MAX_BPP];
        bit                  written[ega_rpd_pkg::COLOR_PLANES][MAX_BPP];
        int                  byte_pos;
        ega_rpd_pkg::plane_t plane;
        logic [5:0]          bpp_reg;
        pixel_t              pending[$];
        int unsigned         mismatches;
        int unsigned         pixels_checked;
        int unsigned         bytes_taken;

        function new();
            byte_pos       = 0;
            plane          = ega_rpd_pkg::PLANE_BLUE;
            bpp_reg        = ega_rpd_pkg::BPP_RESET;
            mismatches     = 0;
            pixels_checked = 0;
            bytes_taken    = 0;
            foreach (written[c, q]) written[c][q] = 1'b0;
        endfunction

        // zero behaves as one, oversize values clamp to the store depth
        function int row_width(logic [5:0] r);
            if (r == 6'd0)
                return 1;
            if (int'(r) > MAX_BPP)
                return MAX_BPP;
            return int'(r);
        endfunction

        function void write_reg(int index, logic [31:0] value);
            if (index == int'(ega_rpd_pkg::CFG_BYTES_PER_PLANE))
                bpp_reg = value[5:0];
        endfunction

        function bit at_row_start();
            return plane == ega_rpd_pkg::PLANE_BLUE && byte_pos == 0;
        endfunction

        // true when a width change now never makes an intensity byte read an
        // unwritten store entry in the rest of the current row
        function bit width_safe(logic [5:0] r);
            int we;
            int lastq;
            bit ok;
            we = row_width(r);
            ok = 1'b1;
            if (plane == ega_rpd_pkg::PLANE_INTENSITY) begin
                lastq = (byte_pos < we) ? we - 1 : byte_pos;
                for (int q = byte_pos; q <= lastq; q++)
                    for (int c = 0; c < ega_rpd_pkg::COLOR_PLANES; c++)
                        if (!written[c][q])
                            ok = 1'b0;
            end
            else begin
                for (int q = 0; q < we; q++)
                    for (int c = 0; c < ega_rpd_pkg::COLOR_PLANES; c++)
                        if (!written[c][q] && !(c > int'(plane))
                            && !(c == int'(plane) && q >= byte_pos && byte_pos < we))
                            ok = 1'b0;
            end
            return ok;
        endfunction

        function logic [23:0] ega_color(logic [3:0] ci);
            ega_rpd_pkg::byte_t on_lvl;
            ega_rpd_pkg::byte_t off_lvl;
            ega_rpd_pkg::byte_t r;
            ega_rpd_pkg::byte_t g;
            ega_rpd_pkg::byte_t b;
            on_lvl  = ci[3] ? ega_rpd_pkg::LVL_HIGH : ega_rpd_pkg::LVL_MID;
            off_lvl = ci[3] ? ega_rpd_pkg::LVL_LOW  : ega_rpd_pkg::LVL_OFF;
            r = ci[2] ? on_lvl : off_lvl;
            g = ci[1] ? on_lvl : off_lvl;
            b = ci[0] ? on_lvl : off_lvl;
            if (ci == IDX_BROWN)
                g = ega_rpd_pkg::LVL_LOW;
            return {r, g, b};
        endfunction

        function void note_byte(ega_rpd_pkg::byte_t data);
            int                 w;
            int                 pos;
            int                 sh;
            ega_rpd_pkg::byte_t bb;
            ega_rpd_pkg::byte_t gb;
            ega_rpd_pkg::byte_t rb;
            pixel_t             px;
            w   = row_width(bpp_reg);
            pos = byte_pos % MAX_BPP;
            bytes_taken++;
            if (plane != ega_rpd_pkg::PLANE_INTENSITY) begin
                plane_bytes[int'(plane)][pos] = data;
                written[int'(plane)][pos]     = 1'b1;
            end
            else begin
                bb = plane_bytes[int'(ega_rpd_pkg::PLANE_BLUE)][pos];
                gb = plane_bytes[int'(ega_rpd_pkg::PLANE_GREEN)][pos];
                rb = plane_bytes[int'(ega_rpd_pkg::PLANE_RED)][pos];
                for (int k = 0; k < ega_rpd_pkg::PIXELS_PER_BYTE; k++) begin
                    sh         = ega_rpd_pkg::PIXELS_PER_BYTE - 1 - k;
                    px.idx     = {data[sh], rb[sh], gb[sh], bb[sh]};
                    {px.red, px.green, px.blue} = ega_color(px.idx);
                    px.column  = 8'(pos * ega_rpd_pkg::PIXELS_PER_BYTE + k);
                    px.last    = (k == ega_rpd_pkg::PIXELS_PER_BYTE - 1);
                    px.row_end = px.last && (pos + 1 >= w);
                    pending.insert(pending.size(), px);
                end
            end
            // step to the next byte, wrapping into the next plane
            if (pos + 1 >= w) begin
                byte_pos = 0;
                case (plane)
                    ega_rpd_pkg::PLANE_BLUE:  plane = ega_rpd_pkg::PLANE_GREEN;
                    ega_rpd_pkg::PLANE_GREEN: plane = ega_rpd_pkg::PLANE_RED;
                    ega_rpd_pkg::PLANE_RED:   plane = ega_rpd_pkg::PLANE_INTENSITY;
                    default:                  plane = ega_rpd_pkg::PLANE_BLUE;
                endcase
            end
            else begin
                byte_pos = pos + 1;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("pixel with nothing expected: idx %0d col %0d",
                             got.idx, got.column);
                return;
            end
            want = pending.pop_front();
            pixels_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("pixel %0d mismatch", pixels_checked);
                    $display("  expected idx %0d rgb %h %h %h col %0d row_end %b last %b",
                             want.idx, want.red, want.green, want.blue, want.column,
                             want.row_end, want.last);
                    $display("  actual   idx %0d rgb %h %h %h col %0d row_end %b last %b",
                             got.idx, got.red, got.green, got.blue, got.column,
                             got.row_end, got.last);
                end
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, buses and the block
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ega_rpd_in_if  in_bus();
    ega_rpd_out_if pix_bus();

    pixel_scoreboard sb = new();

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int unsigned cycles = 0;

    ega_row_planar_pixel_decoder #(
        .MAX_BYTES_PER_PLANE (MAX_BPP)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (pix_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still expected",
                     cycles, sb.outstanding());
            $display("status: fail");
            $finish;
        end
    end

    // pixel receiver: check what was taken at this edge, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && pix_bus.valid && pix_bus.ready)
            sb.check_pixel('{pix_bus.palette_index, pix_bus.red, pix_bus.green,
                             pix_bus.blue, pix_bus.column, pix_bus.row_end,
                             pix_bus.last});
        pix_bus.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one plane byte; valid stays high afterwards so items can go back to back
    task automatic send_byte(ega_rpd_pkg::byte_t data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= data;
        do
            @(posedge clk);
        while (!in_bus.ready);
        sb.note_byte(data);
    endtask

    // stop sending and wait until every expected pixel is out
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(int'(addr >> 2), data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // width change while idle; may land mid-row, unless that would make an
    // intensity byte read a store entry never written
    task automatic set_width(logic [5:0] value);
        logic [31:0] word;
        if (!sb.width_safe(value))
            while (!sb.at_row_start())
                send_byte(ega_rpd_pkg::byte_t'($urandom_range(255)));
        drain();
        word      = $urandom();
        word[5:0] = value;
        apb_write(ADDR_BPP, word);
    endtask

    task automatic run_phase(logic [5:0] value, int idle_pct, int stall_pct,
                             int count, int pause_at);
        set_width(value);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                drain();
            send_byte(ega_rpd_pkg::byte_t'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.data_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width of two: one row walks through all sixteen palette entries
        send_byte(8'h55); send_byte(8'h55);
        send_byte(8'h33); send_byte(8'h33);
        send_byte(8'h0F); send_byte(8'h0F);
        send_byte(8'h00); send_byte(8'hFF);

        // write to an address past the register list must leave the width alone
        drain();
        apb_write(ADDR_SPARE, 32'h0000_0001);

        // all-zero and all-one bytes, still two bytes per plane
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'hFF);

        // register zero acts as a single byte per plane
        set_width(6'd0);
        send_byte(8'hAA); send_byte(8'hCC); send_byte(8'hF0); send_byte(8'h5A);

        // width changed in the middle of a row, between green and red
        send_byte(8'h81); send_byte(8'h7E);
        set_width(6'd2);
        send_byte(8'hC3); send_byte(8'h3C); send_byte(8'h18); send_byte(8'hE7);

        // random content under several widths and idling patterns
        run_phase(6'd32, 0, 0, 128, -1);   // widest row, fills the whole store
        run_phase(6'd63, 68, 0, 40, -1);   // oversize value clamps to the max
        run_phase(6'd5, 0, 68, 40, 20);    // one full pause midway
        run_phase(6'd1, 32, 32, 30, -1);
        run_phase(6'd3, 32, 32, 30, -1);

        drain();
        $display("run covered %0d plane bytes and %0d pixels", sb.bytes_taken,
                 sb.pixels_checked);
        $display("widths 0 to 63 incl. clamping, mid-row width change, stalls on both sides");
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
